/* src/pcs_pkg.sv */
// Shared types and constants for the PLL configuration search block.
// Holds field widths, multiplier windows and the controller/datapath interface.
// No dependencies.
package pcs_pkg;

   localparam int REF_W  = 26;
   localparam int FREQ_W = 27;
   localparam int MOD_W  = 24;
   localparam int SET_W  = 8;
   localparam int DIV_W  = 6;
   localparam int SEL_W  = 2;
   localparam int FDIV_W = 21;
   localparam int FAC_W  = 8;
   localparam int NUM_MUL = 4;

   localparam int PCS_MAX_DIVISOR = 63;
   localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(7372800);

   localparam logic [FAC_W-1:0]  MUL_FACTOR [NUM_MUL] = '{8'd6, 8'd48, 8'd96, 8'd144};
   localparam logic [FDIV_W-1:0] WIN_LOW    [NUM_MUL] =
      '{21'd500000, 21'd850000, 21'd425000, 21'd390000};
   localparam logic [FDIV_W-1:0] WIN_HIGH   [NUM_MUL] =
      '{21'd800000, 21'd1200000, 21'd1000000, 21'd667000};

   typedef struct packed {
      logic             load;
      logic             div_go;
      logic             mod_go;
      logic             mod_ref;
      logic             fdiv_load;
      logic             mul_load;
      logic             bypass_load;
      logic             cand_update;
      logic [DIV_W-1:0] divisor;
      logic [SEL_W-1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic in_window;
      logic best_zero;
   } sts_type;

endpackage

/* src/pcs_divider.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Used for both the pre-divide and the modulus remainder. Depends on pcs_pkg.
module pcs_divider
   import pcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FREQ_W-1:0] dividend,
   input  logic [MOD_W-1:0]  divisor,
   output logic              busy,
   output logic              done,
   output logic [FREQ_W-1:0] quotient,
   output logic [MOD_W-1:0]  remainder
);

   localparam int STEPS = FREQ_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [FREQ_W-1:0] quo_ff, quo_in;
   logic [MOD_W-1:0]  acc_ff, acc_in;
   logic [MOD_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [MOD_W:0]    trial;
   logic [MOD_W+1:0]  diff;
   logic              fits;

   always_comb begin
      trial = {acc_ff, quo_ff[FREQ_W-1]};
      diff  = {1'b0, trial} - {2'b00, dsr_ff};
      fits  = !diff[MOD_W+1];

      quo_in  = quo_ff;
      acc_in  = acc_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = dividend;
         acc_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = fits ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
         quo_in = {quo_ff[FREQ_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      acc_ff <= acc_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = acc_ff;

endmodule

/* src/pcs_datapath.sv */
// Datapath: error modulus register, shared divider, candidate product and best-so-far.
// Driven by cmd_type from pcs_ctrl, reports sts_type. Depends on pcs_pkg, pcs_divider.
module pcs_datapath
   import pcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [REF_W-1:0]  ref_frequency,
   input  logic              csr_write,
   input  logic [MOD_W-1:0]  csr_data,
   output logic [SET_W-1:0]  pll_setting,
   output logic [FREQ_W-1:0] chosen_frequency,
   output logic [MOD_W-1:0]  residual_error
);

   logic [MOD_W-1:0]  modulus_ff, modulus_in;
   logic [REF_W-1:0]  ref_ff, ref_in;
   logic [REF_W-1:0]  fdiv_ff, fdiv_in;
   logic [FREQ_W-1:0] cand_ff, cand_in;
   logic [MOD_W-1:0]  best_error_ff, best_error_in;
   logic [FREQ_W-1:0] best_freq_ff, best_freq_in;
   logic [SET_W-1:0]  best_set_ff, best_set_in;

   logic [MOD_W-1:0]  mod_eff;
   logic [FREQ_W-1:0] div_dividend;
   logic [MOD_W-1:0]  div_divisor;
   logic              div_busy;
   logic              div_done;
   logic [FREQ_W-1:0] div_quo;
   logic [MOD_W-1:0]  div_rem;
   logic [FDIV_W+FAC_W-1:0] product;
   logic              in_window;

   always_comb begin
      mod_eff = (modulus_ff == '0) ? MOD_W'(1) : modulus_ff;
      if (cmd.div_go) begin
         div_dividend = FREQ_W'(ref_ff) + FREQ_W'(cmd.divisor[DIV_W-1:1]);
         div_divisor  = MOD_W'(cmd.divisor);
      end else begin
         div_dividend = cmd.mod_ref ? FREQ_W'(ref_ff) : cand_ff;
         div_divisor  = mod_eff;
      end
      in_window = (fdiv_ff >= REF_W'(WIN_LOW[cmd.sel]))
               && (fdiv_ff <= REF_W'(WIN_HIGH[cmd.sel]));
      product   = fdiv_ff[FDIV_W-1:0] * MUL_FACTOR[cmd.sel];
   end

   pcs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_go || cmd.mod_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      modulus_in    = csr_write ? csr_data : modulus_ff;
      ref_in        = cmd.load ? ref_frequency : ref_ff;
      fdiv_in       = cmd.fdiv_load ? div_quo[REF_W-1:0] : fdiv_ff;
      cand_in       = cmd.mul_load ? product[FREQ_W-1:0] : cand_ff;
      best_error_in = best_error_ff;
      best_freq_in  = best_freq_ff;
      best_set_in   = best_set_ff;
      if (cmd.bypass_load) begin
         best_error_in = div_rem;
         best_freq_in  = FREQ_W'(ref_ff);
         best_set_in   = '0;
      end else if (cmd.cand_update && (div_rem < best_error_ff)) begin
         best_error_in = div_rem;
         best_freq_in  = cand_ff;
         best_set_in   = {cmd.sel, cmd.divisor};
      end
   end

   always_ff @(posedge clock) begin
      ref_ff  <= ref_in;
      fdiv_ff <= fdiv_in;
      cand_ff <= cand_in;
      if (reset) begin
         modulus_ff    <= MODULUS_RESET;
         best_error_ff <= '0;
         best_freq_ff  <= '0;
         best_set_ff   <= '0;
      end else begin
         modulus_ff    <= modulus_in;
         best_error_ff <= best_error_in;
         best_freq_ff  <= best_freq_in;
         best_set_ff   <= best_set_in;
      end
   end

   assign sts.div_done  = div_done;
   assign sts.in_window = in_window;
   assign sts.best_zero = (best_error_ff == '0);

   assign pll_setting      = best_set_ff;
   assign chosen_frequency = best_freq_ff;
   assign residual_error   = best_error_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_go || cmd.mod_go) |-> !div_busy)
      else $error("divider restarted while busy");

   a_update_monotone: assert property (@(posedge clock) disable iff (reset)
      cmd.cand_update |=> best_error_ff <= $past(best_error_ff))
      else $error("best error grew on candidate update");

   a_mul_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_load |-> in_window)
      else $error("candidate formed outside its window");

endmodule

/* src/pcs_ctrl.sv */
// Search sequencer: walks bypass, divisors and multiplier selects.
// Issues cmd_type to pcs_datapath, reads sts_type. Depends on pcs_pkg.
module pcs_ctrl
   import pcs_pkg::*;
#(
   parameter int MAX_DIVISOR = PCS_MAX_DIVISOR
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    respond,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_BYP_GO    = 12'b0000_0000_0010,
      ST_BYP_WAIT  = 12'b0000_0000_0100,
      ST_LOOP_TEST = 12'b0000_0000_1000,
      ST_DIV_GO    = 12'b0000_0001_0000,
      ST_DIV_WAIT  = 12'b0000_0010_0000,
      ST_WIN       = 12'b0000_0100_0000,
      ST_MOD_GO    = 12'b0000_1000_0000,
      ST_MOD_WAIT  = 12'b0001_0000_0000,
      ST_NEXT_K    = 12'b0010_0000_0000,
      ST_NEXT_D    = 12'b0100_0000_0000,
      ST_DONE      = 12'b1000_0000_0000
   } state_type;

   localparam logic [DIV_W-1:0] LAST_D = DIV_W'(MAX_DIVISOR);

   state_type        state_ff, state_in;
   logic [DIV_W-1:0] d_ff, d_in;
   logic [SEL_W-1:0] k_ff, k_in;

   always_comb begin
      state_in = state_ff;
      d_in     = d_ff;
      k_in     = k_ff;
      cmd              = '0;
      cmd.divisor      = d_ff;
      cmd.sel          = k_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_BYP_GO;
            end
         end
         ST_BYP_GO: begin
            cmd.mod_go  = 1'b1;
            cmd.mod_ref = 1'b1;
            state_in    = ST_BYP_WAIT;
         end
         ST_BYP_WAIT: begin
            if (sts.div_done) begin
               cmd.bypass_load = 1'b1;
               d_in            = DIV_W'(1);
               state_in        = ST_LOOP_TEST;
            end
         end
         ST_LOOP_TEST: begin
            state_in = sts.best_zero ? ST_DONE : ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.fdiv_load = 1'b1;
               k_in          = '0;
               state_in      = ST_WIN;
            end
         end
         ST_WIN: begin
            if (sts.in_window) begin
               cmd.mul_load = 1'b1;
               state_in     = ST_MOD_GO;
            end else begin
               state_in = ST_NEXT_K;
            end
         end
         ST_MOD_GO: begin
            cmd.mod_go = 1'b1;
            state_in   = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (sts.div_done) begin
               cmd.cand_update = 1'b1;
               state_in        = ST_NEXT_K;
            end
         end
         ST_NEXT_K: begin
            if (k_ff == SEL_W'(NUM_MUL - 1)) begin
               state_in = ST_NEXT_D;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_WIN;
            end
         end
         ST_NEXT_D: begin
            if (d_ff == LAST_D) begin
               state_in = ST_DONE;
            end else begin
               d_in     = d_ff + 1'b1;
               state_in = ST_LOOP_TEST;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         d_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         d_ff     <= d_in;
         k_ff     <= k_in;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign respond = (state_ff == ST_DONE);

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_BYP_WAIT || state_ff == ST_DIV_WAIT
                        || state_ff == ST_MOD_WAIT))
      else $error("divider finished outside a wait state");

   a_respond_idle: assert property (@(posedge clock) disable iff (reset)
      respond |=> !busy)
      else $error("not idle after result");

   a_no_search_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_GO) |-> !sts.best_zero)
      else $error("search continued after exact match");

endmodule

/* src/pll_config_search.sv */
// A search ends straight after the bypass check when bypass is exact; otherwise it examines
// divisors in turn, with one modulus step per in-window multiplier, until exact or the last divisor.
// Every divider and modulus step runs on the one shared radix-2 divider.
// Throughput: one item at a time; busy stays high until the rsp_valid cycle ends.
// rsp_valid is a one-cycle strobe the receiver cannot stall.
// Reset (synchronous): idle, error modulus 7372800, result registers cleared.
module pll_config_search
   import pcs_pkg::*;
#(
   parameter int MAX_DIVISOR = PCS_MAX_DIVISOR
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [REF_W-1:0]  req_ref_frequency,
   output logic              rsp_valid,
   output logic [SET_W-1:0]  rsp_pll_setting,
   output logic              rsp_use_pll,
   output logic [FREQ_W-1:0] rsp_chosen_frequency,
   output logic [MOD_W-1:0]  rsp_residual_error,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [MOD_W-1:0]  csr_error_modulus
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   pcs_ctrl #(
      .MAX_DIVISOR (MAX_DIVISOR)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .respond (rsp_valid),
      .cmd     (cmd),
      .sts     (sts)
   );

   pcs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .ref_frequency    (req_ref_frequency),
      .csr_write        (csr_valid && csr_ready),
      .csr_data         (csr_error_modulus),
      .pll_setting      (rsp_pll_setting),
      .chosen_frequency (rsp_chosen_frequency),
      .residual_error   (rsp_residual_error)
   );

   assign rsp_use_pll = (rsp_pll_setting != '0);

endmodule

/* verif/pll_search_checker.sv */
// Checker for pll_config_search: tracks the error modulus written on the csr port,
// predicts the best PLL set-up for every accepted item and compares each result strobe.
// Depends on pcs_pkg for port widths.
module pll_search_checker
   import pcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [REF_W-1:0]  req_ref_frequency,
   input  logic              rsp_valid,
   input  logic [SET_W-1:0]  rsp_pll_setting,
   input  logic              rsp_use_pll,
   input  logic [FREQ_W-1:0] rsp_chosen_frequency,
   input  logic [MOD_W-1:0]  rsp_residual_error,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [MOD_W-1:0]  csr_error_modulus,
   output int                mismatch_count,
   output int                setups_pending,
   output int                setups_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {SEL_X6, SEL_X48, SEL_X96, SEL_X144} mul_sel_type;

   typedef struct packed {
      logic [REF_W-1:0]  ref_hz;
      logic [SET_W-1:0]  setting;
      logic              use_pll;
      logic [FREQ_W-1:0] freq;
      logic [MOD_W-1:0]  resid;
   } pll_setup_type;

   localparam int unsigned DIVISOR_LIMIT = 63;
   localparam logic [MOD_W-1:0] MODULUS_AT_RESET = 24'd7372800;
   localparam int unsigned MUL_TIMES [4] = '{6, 48, 96, 144};
   localparam int unsigned FDIV_MIN  [4] = '{500000, 850000, 425000, 390000};
   localparam int unsigned FDIV_MAX  [4] = '{800000, 1200000, 1000000, 667000};

   logic [MOD_W-1:0] error_modulus;
   pll_setup_type    expected_setups [$];

   // bypass first, then each divisor and in-window multiplier until exact; strict improvement only
   function automatic pll_setup_type search_best_setup(input logic [REF_W-1:0] f_ref,
                                                       input logic [MOD_W-1:0] modulus);
      int unsigned   m;
      int unsigned   fdiv;
      int unsigned   fmul;
      int unsigned   err;
      mul_sel_type   sel;
      pll_setup_type best;
      m = (modulus == '0) ? 1 : int'(modulus);
      best.ref_hz   = f_ref;
      best.setting  = '0;
      best.freq     = FREQ_W'(f_ref);
      best.resid    = MOD_W'(int'(f_ref) % m);
      for (int unsigned d = 1; d <= DIVISOR_LIMIT && best.resid != '0; d++) begin
         fdiv = (int'(f_ref) + d / 2) / d;
         for (int k = 0; k < 4; k++) begin
            if (fdiv >= FDIV_MIN[k] && fdiv <= FDIV_MAX[k]) begin
               fmul = fdiv * MUL_TIMES[k];
               err  = fmul % m;
               if (err < best.resid) begin
                  sel          = mul_sel_type'(k);
                  best.resid   = MOD_W'(err);
                  best.freq    = FREQ_W'(fmul);
                  best.setting = {sel, DIV_W'(d)};
               end
            end
         end
      end
      best.use_pll = (best.setting != '0);
      return best;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      pll_setup_type want;
      if (reset) begin
         error_modulus  = MODULUS_AT_RESET;
         mismatch_count = 0;
         setups_checked = 0;
         expected_setups.delete();
      end else begin
         if (csr_valid && csr_ready)
            error_modulus = csr_error_modulus;
         if (start && !busy)
            expected_setups.push_back(search_best_setup(req_ref_frequency, error_modulus));
         if (rsp_valid) begin
            if (expected_setups.size() == 0) begin
               report_mismatch($sformatf("result with no item pending, setting %0d",
                                         rsp_pll_setting));
            end else begin
               want = expected_setups.pop_front();
               setups_checked++;
               if (rsp_pll_setting !== want.setting)
                  report_mismatch($sformatf("ref %0d modulus %0d: pll_setting %0d, want %0d",
                     want.ref_hz, error_modulus, rsp_pll_setting, want.setting));
               if (rsp_use_pll !== want.use_pll)
                  report_mismatch($sformatf("ref %0d modulus %0d: use_pll %0d, want %0d",
                     want.ref_hz, error_modulus, rsp_use_pll, want.use_pll));
               if (rsp_chosen_frequency !== want.freq)
                  report_mismatch($sformatf("ref %0d modulus %0d: frequency %0d, want %0d",
                     want.ref_hz, error_modulus, rsp_chosen_frequency, want.freq));
               if (rsp_residual_error !== want.resid)
                  report_mismatch($sformatf("ref %0d modulus %0d: residual %0d, want %0d",
                     want.ref_hz, error_modulus, rsp_residual_error, want.resid));
            end
         end
      end
      setups_pending <= expected_setups.size();
   end

endmodule

/* verif/tb_top.sv */
// Top of the pll_config_search testbench: clock, reset, item and csr stimulus, verdict.
// Instantiates the block and pll_search_checker; depends on pcs_pkg.
module tb_top
   import pcs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT     = 50000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 64;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int NUM_PHASES      = 9;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [REF_W-1:0]  req_ref_frequency = '0;
   logic              rsp_valid;
   logic [SET_W-1:0]  rsp_pll_setting;
   logic              rsp_use_pll;
   logic [FREQ_W-1:0] rsp_chosen_frequency;
   logic [MOD_W-1:0]  rsp_residual_error;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [MOD_W-1:0]  csr_error_modulus = '0;

   int mismatch_count;
   int setups_pending;
   int setups_checked;
   int quiet_cycles = 0;
   int items_sent = 0;
   int moduli_written = 0;

   always #5 clock = ~clock;

   pll_config_search i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_ref_frequency    (req_ref_frequency),
      .rsp_valid            (rsp_valid),
      .rsp_pll_setting      (rsp_pll_setting),
      .rsp_use_pll          (rsp_use_pll),
      .rsp_chosen_frequency (rsp_chosen_frequency),
      .rsp_residual_error   (rsp_residual_error),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_error_modulus    (csr_error_modulus)
   );

   pll_search_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_ref_frequency    (req_ref_frequency),
      .rsp_valid            (rsp_valid),
      .rsp_pll_setting      (rsp_pll_setting),
      .rsp_use_pll          (rsp_use_pll),
      .rsp_chosen_frequency (rsp_chosen_frequency),
      .rsp_residual_error   (rsp_residual_error),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_error_modulus    (csr_error_modulus),
      .mismatch_count       (mismatch_count),
      .setups_pending       (setups_pending),
      .setups_checked       (setups_checked)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic send_setup(input logic [REF_W-1:0] f, input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         // line the next item up against the end of the current search
         start <= 1'b0;
         do @(posedge clock); while (busy);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_ref_frequency <= f;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (setups_pending != 0);
   endtask

   task automatic write_modulus(input logic [MOD_W-1:0] m);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_error_modulus <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      moduli_written++;
   endtask

   function automatic logic [REF_W-1:0] draw_reference();
      case ($urandom_range(0, 5))
         0: return REF_W'($urandom);
         1: return REF_W'($urandom_range(0, 50000000));
         2: return REF_W'($urandom_range(0, 1300000));
         3: return REF_W'($urandom_range(1, 36) * 1843200 + $urandom_range(0, 2));
         4: return REF_W'($urandom_range(1, 63) * $urandom_range(390000, 1200000));
         default: return REF_W'($urandom_range(49000000, 67108863));
      endcase
   endfunction

   initial begin
      logic [REF_W-1:0] corner_refs [22];
      logic [MOD_W-1:0] modulus_plan [NUM_PHASES];
      bit               steady;
      corner_refs = '{26'd0, 26'd1, 26'd67108863, 26'd50000000, 26'd7372800, 26'd14745600,
                      26'd1843200, 26'd3686400, 26'd12000000, 26'd16000000, 26'd24000000,
                      26'd25000000, 26'd390000, 26'd425000, 26'd500000, 26'd667000,
                      26'd800000, 26'd1200000, 26'd10000000, 26'd19200000, 26'd33554432,
                      26'd33554431};
      modulus_plan = '{24'd16777215, 24'd0, 24'd1, 24'd614400, 24'd153600, 24'd7372800,
                       MOD_W'($urandom_range(2, 64)), MOD_W'($urandom_range(1000, 200000)),
                       MOD_W'($urandom)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners of the reference range under the reset modulus
      foreach (corner_refs[i])
         send_setup(corner_refs[i], 1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_modulus(modulus_plan[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 27 == 0)
               steady = ($urandom_range(0, 2) == 0);
            send_setup(draw_reference(), steady);
            if ($urandom_range(0, 49) == 0)
               drain_results();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("searched %0d reference frequencies, %0d results compared", items_sent,
               setups_checked);
      $display("%0d error modulus writes, zero and full scale among them", moduli_written);
      if (mismatch_count == 0 && setups_pending == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
src/pcs_pkg.sv
src/pcs_divider.sv
src/pcs_datapath.sv
src/pcs_ctrl.sv
src/pll_config_search.sv
verif/pll_search_checker.sv
verif/tb_top.sv
